[hw/rtl/packed_text_unpacker_top_assert.svh]
// Assertion macros used by the packed text unpacker checker
`ifndef PACKED_TEXT_UNPACKER_TOP_ASSERT_SVH
`define PACKED_TEXT_UNPACKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PTU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ptu_pkg.sv]
// Package: constants, types and tables of the packed text unpacker
package ptu_pkg;

    localparam int MAX_FIELD_BYTES = 255;
    localparam int BYTE_CNT_W      = $clog2(MAX_FIELD_BYTES + 1);
    localparam int CHAR_CNT_W      = 9;

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_BCD  = 2'd1;
    localparam logic [1:0] MODE_SIX  = 2'd2;

    localparam logic [1:0] PHASE_ALIGNED = 2'd0;
    localparam logic [1:0] PHASE_ONE     = 2'd1;
    localparam logic [1:0] PHASE_TWO     = 2'd2;

    localparam logic       REG_MODE  = 1'b0;
    localparam logic       REG_LIMIT = 1'b1;

    localparam logic [7:0] SIX_BASE = 8'h20;

    // One decoded byte: one or two characters waiting for the output side
    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic       two;
        logic       se0;
        logic       se1;
    } job_t;

    function automatic logic [7:0] bcd_char(input logic [3:0] nib);
        logic [7:0] ch;
        case (nib)
            4'd10:   ch = 8'h20;
            4'd11:   ch = 8'h2d;
            4'd12:   ch = 8'h2e;
            4'd13:   ch = 8'h3a;
            4'd14:   ch = 8'h2c;
            4'd15:   ch = 8'h5f;
            default: ch = 8'h30 + {4'd0, nib};
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/packed_text_unpacker_top.sv]
// An accepted byte is written into the job queue, then loaded into the output register.
// The output register takes one character per cycle while it is not stalled, so one byte per
// cycle in pass-through and one-character six-bit phases; each pair goes out in character order.
// The two-entry job queue lets the front take bytes while the output is stalled.
// Reset (rst_n low, asynchronous): mode pass-through, limit 511, alignment and counts cleared.
module packed_text_unpacker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] packed_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // [0] run_end
);

    logic [1:0]    mode_reg,  mode_next;
    logic [8:0]    limit_reg, limit_next;
    logic          wr_en;
    logic          q_full;
    logic          push;
    logic          pop;
    logic          head_valid;
    ptu_pkg::job_t push_job;
    ptu_pkg::job_t head_job;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ptu_pkg::REG_LIMIT) ? {23'd0, limit_reg} : {30'd0, mode_reg};

    always_comb
    begin
        mode_next  = mode_reg;
        limit_next = limit_reg;
        if (wr_en)
        begin
            case (paddr[2])
                ptu_pkg::REG_MODE:  mode_next  = pwdata[1:0];
                ptu_pkg::REG_LIMIT: limit_next = pwdata[8:0];
                default:            mode_next  = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ptu_pkg::MODE_PASS;
            limit_reg <= 9'd511;
        end
        else
        begin
            mode_reg  <= mode_next;
            limit_reg <= limit_next;
        end
    end

    ptu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .limit    (limit_reg),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_fin   (s_axis_tlast),
        .in_ready (s_axis_tready),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    ptu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    ptu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (m_axis_tdata),
        .run_end    (m_axis_tuser[0]),
        .string_end (m_axis_tlast)
    );

endmodule

[hw/rtl/ptu_front.sv]
// Front end: takes one packed byte, updates string state, builds a job
module ptu_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   mode,
    input  logic [8:0]                   limit,
    input  logic                         in_valid,
    input  logic [7:0]                   in_byte,
    input  logic                         in_fin,
    output logic                         in_ready,
    input  logic                         q_full,
    output logic                         push,
    output ptu_pkg::job_t                job
);

    logic [1:0]                       phase_reg,   phase_next;
    logic [3:0]                       carry_reg,   carry_next;
    logic [ptu_pkg::CHAR_CNT_W-1:0]   emitted_reg, emitted_next;
    logic [ptu_pkg::BYTE_CNT_W-1:0]   seen_reg,    seen_next;

    logic                             accept;
    logic                             active;
    logic                             last;
    logic [ptu_pkg::BYTE_CNT_W:0]     seen_inc;
    logic [7:0]                       ch0;
    logic [7:0]                       ch1;
    logic [1:0]                       cnt;
    logic [8:0]                       cap;
    logic [5:0]                       code0;
    logic [5:0]                       code1;
    logic [1:0]                       six_phase;
    logic [3:0]                       six_carry;
    logic                             six_two;
    logic                             e0;
    logic                             e1;
    logic [ptu_pkg::CHAR_CNT_W-1:0]   ce1;
    logic [ptu_pkg::CHAR_CNT_W:0]     ce_p1;
    logic [ptu_pkg::CHAR_CNT_W:0]     ce1_p1;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign seen_inc = {1'b0, seen_reg} + 1'b1;
    assign active   = seen_reg < ptu_pkg::BYTE_CNT_W'(ptu_pkg::MAX_FIELD_BYTES);
    assign last     = in_fin
                   || (seen_inc >= (ptu_pkg::BYTE_CNT_W + 1)'(ptu_pkg::MAX_FIELD_BYTES));

    // six-bit unpack, LSB first
    always_comb
    begin
        code1 = in_byte[7:2];
        case (phase_reg)
            ptu_pkg::PHASE_ONE:
            begin
                code0     = {in_byte[3:0], carry_reg[1:0]};
                six_carry = in_byte[7:4];
                six_phase = ptu_pkg::PHASE_TWO;
                six_two   = 1'b0;
            end
            ptu_pkg::PHASE_TWO:
            begin
                code0     = {in_byte[1:0], carry_reg};
                six_carry = 4'd0;
                six_phase = ptu_pkg::PHASE_ALIGNED;
                six_two   = 1'b1;
            end
            default:
            begin
                code0     = in_byte[5:0];
                six_carry = {2'b00, in_byte[7:6]};
                six_phase = ptu_pkg::PHASE_ONE;
                six_two   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (mode)
            ptu_pkg::MODE_PASS:
            begin
                ch0 = in_byte;
                ch1 = in_byte;
                cnt = 2'd1;
                cap = (limit != 9'd0) ? limit - 9'd1 : 9'd0;
            end
            ptu_pkg::MODE_BCD:
            begin
                ch0 = ptu_pkg::bcd_char(in_byte[3:0]);
                ch1 = ptu_pkg::bcd_char(in_byte[7:4]);
                cnt = 2'd2;
                cap = limit;
            end
            ptu_pkg::MODE_SIX:
            begin
                ch0 = {2'b00, code0} + ptu_pkg::SIX_BASE;
                ch1 = {2'b00, code1} + ptu_pkg::SIX_BASE;
                cnt = six_two ? 2'd2 : 2'd1;
                cap = limit;
            end
            default:
            begin
                ch0 = in_byte;
                ch1 = in_byte;
                cnt = 2'd0;
                cap = 9'd0;
            end
        endcase
    end

    assign e0     = (cnt != 2'd0) && (emitted_reg < cap);
    assign ce1    = emitted_reg + {{(ptu_pkg::CHAR_CNT_W-1){1'b0}}, e0};
    assign e1     = (cnt == 2'd2) && (ce1 < cap);
    assign ce_p1  = {1'b0, emitted_reg} + 1'b1;
    assign ce1_p1 = {1'b0, ce1} + 1'b1;

    always_comb
    begin
        job.c0  = ch0;
        job.c1  = ch1;
        job.two = e1;
        job.se0 = (ce_p1 == {1'b0, cap}) || (last && (cnt == 2'd1));
        job.se1 = (ce1_p1 == {1'b0, cap}) || last;
    end

    assign push = accept && active && e0;

    always_comb
    begin
        phase_next   = phase_reg;
        carry_next   = carry_reg;
        emitted_next = emitted_reg;
        seen_next    = seen_reg;
        if (accept)
        begin
            if (active)
            begin
                seen_next    = seen_inc[ptu_pkg::BYTE_CNT_W-1:0];
                emitted_next = ce1 + {{(ptu_pkg::CHAR_CNT_W-1){1'b0}}, e1};
                if (mode == ptu_pkg::MODE_SIX)
                begin
                    phase_next = six_phase;
                    carry_next = six_carry;
                end
            end
            if (in_fin)
            begin
                phase_next   = ptu_pkg::PHASE_ALIGNED;
                carry_next   = 4'd0;
                emitted_next = '0;
                seen_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ptu_pkg::PHASE_ALIGNED;
            carry_reg   <= 4'd0;
            emitted_reg <= '0;
            seen_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            carry_reg   <= carry_next;
            emitted_reg <= emitted_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

[hw/rtl/ptu_fifo.sv]
// Two-entry job queue between the front end and the output side
module ptu_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ptu_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output ptu_pkg::job_t head_job
);

    ptu_pkg::job_t mem_reg [2];
    logic          wptr_reg, wptr_next;
    logic          rptr_reg, rptr_next;
    logic [1:0]    count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_job   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/ptu_back.sv]
// Back end: walks each job one character at a time into the output register
module ptu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  ptu_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_char,
    output logic          run_end,
    output logic          string_end
);

    logic       valid_reg, valid_next;
    logic       sel_reg,   sel_next;
    logic [7:0] char_reg;
    logic       run_reg;
    logic       str_reg;
    logic       load;
    logic       tail;

    assign load = head_valid && (!valid_reg || out_ready);
    assign tail = sel_reg || !head_job.two;
    assign pop  = load && tail;

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sel_next   = !tail;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= sel_reg ? head_job.c1 : head_job.c0;
            run_reg  <= tail;
            str_reg  <= sel_reg ? head_job.se1 : head_job.se0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_char   = char_reg;
    assign run_end    = run_reg;
    assign string_end = str_reg;

endmodule

[hw/rtl/ptu_checker.sv]
// Port-level checker for the packed text unpacker, bound to the top level
`include "packed_text_unpacker_top_assert.svh"

module ptu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    `PTU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
        && $stable(m_axis_tuser), "stalled output word changed")
    `PTU_ASSERT_SAME(a_str_end_run, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0],
        "string end without run end")
    `PTU_ASSERT_SAME(a_full_busy, !s_axis_tready, m_axis_tvalid,
        "input stalled while output idle")

endmodule

bind packed_text_unpacker_top ptu_checker u_ptu_checker (.*);

[dv/packed_text_unpacker_top_tb.sv]
// Testbench for packed_text_unpacker_top: directed and random text fields checked against a predictor
module packed_text_unpacker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]   MODE_UNUSED    = 2'd3;
    localparam logic [2:0]   ADDR_MODE      = {ptu_pkg::REG_MODE, 2'b00};
    localparam logic [2:0]   ADDR_LIMIT     = {ptu_pkg::REG_LIMIT, 2'b00};
    localparam logic [127:0] BCD_GLYPHS     = "0123456789 -.:,_";
    localparam int           SETTLE_CYCLES  = 8;
    localparam int           HOLD_CYCLES    = 300;
    localparam int           WATCHDOG_LIMIT = 4000;
    localparam int           PHASE_ITEMS    = 55;

    typedef struct packed {
        logic [7:0] code;
        logic       run_end;
        logic       string_end;
    } text_char_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] packed_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_char
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;   // [0] run_end

    packed_text_unpacker_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    text_char_t expected_chars[$];
    int         error_count = 0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    bit         hold_request = 0;

    logic [1:0] cfg_mode;
    logic [8:0] cfg_limit;
    logic [1:0] six_phase;
    logic [3:0] six_carry;
    int         chars_out;
    int         field_bytes;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic clear_field();
        six_phase   = ptu_pkg::PHASE_ALIGNED;
        six_carry   = 4'd0;
        chars_out   = 0;
        field_bytes = 0;
    endtask

    // expected characters for one accepted word
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] glyph [2];
        logic [5:0] code [2];
        text_char_t res [2];
        int         cnt;
        int         n;
        int         cap;
        logic       last;
        cnt = 0;
        n   = 0;
        cap = 0;
        if (field_bytes < ptu_pkg::MAX_FIELD_BYTES)
        begin
            last = fin || (field_bytes + 1 >= ptu_pkg::MAX_FIELD_BYTES);
            field_bytes++;
            case (cfg_mode)
                ptu_pkg::MODE_PASS:
                begin
                    glyph[0] = b;
                    cnt = 1;
                    cap = (cfg_limit > 0) ? int'(cfg_limit) - 1 : 0;
                end
                ptu_pkg::MODE_BCD:
                begin
                    glyph[0] = BCD_GLYPHS[8 * (15 - int'(b[3:0])) +: 8];
                    glyph[1] = BCD_GLYPHS[8 * (15 - int'(b[7:4])) +: 8];
                    cnt = 2;
                    cap = int'(cfg_limit);
                end
                ptu_pkg::MODE_SIX:
                begin
                    case (six_phase)
                        ptu_pkg::PHASE_ONE:
                        begin
                            code[0]   = {b[3:0], six_carry[1:0]};
                            six_carry = b[7:4];
                            six_phase = ptu_pkg::PHASE_TWO;
                            cnt = 1;
                        end
                        ptu_pkg::PHASE_TWO:
                        begin
                            code[0]   = {b[1:0], six_carry};
                            code[1]   = b[7:2];
                            six_carry = 4'd0;
                            six_phase = ptu_pkg::PHASE_ALIGNED;
                            cnt = 2;
                        end
                        default:
                        begin
                            code[0]   = b[5:0];
                            six_carry = {2'b00, b[7:6]};
                            six_phase = ptu_pkg::PHASE_ONE;
                            cnt = 1;
                        end
                    endcase
                    for (int i = 0; i < cnt; i++)
                        glyph[i] = ptu_pkg::SIX_BASE + {2'b00, code[i]};
                    cap = int'(cfg_limit);
                end
                default:
                    cap = 0;
            endcase
            for (int i = 0; i < cnt; i++)
            begin
                if (chars_out < cap)
                begin
                    chars_out++;
                    res[n].code       = glyph[i];
                    res[n].run_end    = 1'b0;
                    res[n].string_end = (chars_out == cap) || (last && i == cnt - 1);
                    n++;
                end
            end
            if (n > 0)
                res[n - 1].run_end = 1'b1;
            for (int i = 0; i < n; i++)
                expected_chars.push_back(res[i]);
        end
        if (fin)
            clear_field();
    endtask

    // entered and left just after a falling edge
    task automatic offer_byte(input logic [7:0] b, input logic fin);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct)
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_byte(b, fin);
        @(negedge clk);
    endtask

    task automatic send_field(input int len);
        for (int i = 0; i < len; i++)
            offer_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_MODE)
            cfg_mode = data[1:0];
        else if (addr == ADDR_LIMIT)
            cfg_limit = data[8:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [1:0] mode, input logic [8:0] limit);
        write_reg(ADDR_MODE, {30'd0, mode});
        write_reg(ADDR_LIMIT, {23'd0, limit});
    endtask

    function automatic logic [8:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd511;
            3, 4:    return 9'($urandom_range(2, 24));
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return ptu_pkg::MODE_PASS;
        else if (r < 6)
            return ptu_pkg::MODE_BCD;
        else if (r < 9)
            return ptu_pkg::MODE_SIX;
        return MODE_UNUSED;
    endfunction

    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // reset settings: pass-through, limit 511
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hff, 1'b0);
        offer_byte(8'ha5, 1'b1);
        // zero limit in pass-through
        configure(ptu_pkg::MODE_PASS, 9'd0);
        offer_byte(8'h41, 1'b1);
        // cap of two characters
        write_reg(ADDR_LIMIT, 32'd3);
        offer_byte(8'h11, 1'b0);
        offer_byte(8'h22, 1'b0);
        offer_byte(8'h33, 1'b1);
        // every BCD-plus nibble
        configure(ptu_pkg::MODE_BCD, 9'd511);
        offer_byte(8'h10, 1'b0);
        offer_byte(8'h32, 1'b0);
        offer_byte(8'h54, 1'b0);
        offer_byte(8'h76, 1'b0);
        offer_byte(8'h98, 1'b0);
        offer_byte(8'hba, 1'b0);
        offer_byte(8'hdc, 1'b0);
        offer_byte(8'hfe, 1'b1);
        // cap hit on the first character of a pair
        write_reg(ADDR_LIMIT, 32'd3);
        offer_byte(8'h21, 1'b0);
        offer_byte(8'h43, 1'b1);
        // six-bit: '@' code, full group, dropped leftover bits
        configure(ptu_pkg::MODE_SIX, 9'd511);
        offer_byte(8'h20, 1'b0);
        offer_byte(8'hff, 1'b0);
        offer_byte(8'hff, 1'b0);
        offer_byte(8'h3f, 1'b1);
        // unused mode
        write_reg(ADDR_MODE, {30'd0, MODE_UNUSED});
        offer_byte(8'h55, 1'b1);
        // mode switched mid-string keeps alignment
        write_reg(ADDR_MODE, {30'd0, ptu_pkg::MODE_SIX});
        offer_byte(8'hab, 1'b0);
        write_reg(ADDR_MODE, {30'd0, ptu_pkg::MODE_PASS});
        offer_byte(8'h12, 1'b0);
        write_reg(ADDR_MODE, {30'd0, ptu_pkg::MODE_SIX});
        offer_byte(8'h34, 1'b0);
        offer_byte(8'h56, 1'b1);
        // limit lowered mid-string below what was sent
        configure(ptu_pkg::MODE_BCD, 9'd511);
        offer_byte(8'h98, 1'b0);
        write_reg(ADDR_LIMIT, 32'd1);
        offer_byte(8'h76, 1'b1);
    endtask

    task automatic test_field_length();
        configure(ptu_pkg::MODE_SIX, 9'd511);
        send_field(ptu_pkg::MAX_FIELD_BYTES + 3);
        configure(ptu_pkg::MODE_PASS, 9'd511);
        send_field(ptu_pkg::MAX_FIELD_BYTES + 1);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        int sent;
        int len;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                configure(pick_mode(), pick_limit());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if ($urandom_range(0, 7) == 0 && len > 1)
            begin
                // change one register partway through the field
                for (int i = 0; i < len / 2; i++)
                    offer_byte(8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 1) == 0)
                    write_reg(ADDR_MODE, {30'd0, pick_mode()});
                else
                    write_reg(ADDR_LIMIT, {23'd0, pick_limit()});
                send_field(len - len / 2);
            end
            else
                send_field(len);
            sent += len;
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        configure(ptu_pkg::MODE_BCD, 9'd511);
        hold_request = 1'b1;
        send_field(30);
        wait_drained();
        configure(ptu_pkg::MODE_SIX, 9'd511);
        send_field(12);
    endtask

    // result side: random stalls and one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected word: out_char %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_axis_tdata !== want.code)
                begin
                    $error("out_char: expected %h, got %h", want.code, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.run_end)
                begin
                    $error("run_end: expected %b, got %b", want.run_end, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tlast !== want.string_end)
                begin
                    $error("string_end: expected %b, got %b", want.string_end, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("packed_text_unpacker_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        cfg_mode      = ptu_pkg::MODE_PASS;
        cfg_limit     = 9'd511;
        clear_field();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_field_length();
        test_random_phase(0, 0);
        test_random_phase(56, 0);
        test_random_phase(0, 56);
        test_random_phase(38, 38);
        test_backpressure();

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("packed_text_unpacker_top_tb OK");
        else
            $display("packed_text_unpacker_top_tb NOT OK");
        $finish;
    end

endmodule
